### hw/rtl/pai_pkg.sv
// shared types and constants of the positional array insert/delete unit
package pai_pkg;

  localparam int unsigned OpW    = 3;
  localparam int unsigned PosW   = 5;
  localparam int unsigned ValW   = 32;
  localparam int unsigned StW    = 2;
  localparam int unsigned IdxW   = 5;
  localparam int unsigned CountW = 6;
  localparam int unsigned CmpW   = 7;
  localparam int unsigned MaxRead = 32;

  typedef enum logic [OpW-1:0] {
    OP_CLEAR  = 3'd0,
    OP_APPEND = 3'd1,
    OP_INSERT = 3'd2,
    OP_DELETE = 3'd3,
    OP_READ   = 3'd4
  } op_e;

  typedef enum logic [StW-1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_BAD_POS = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    SEL_HOLD,
    SEL_LOAD,
    SEL_LO,
    SEL_HI,
    SEL_HEAD
  } sel_e;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_e;

endpackage

### hw/rtl/pai_in_if.sv
// request channel of the positional array insert/delete unit
interface pai_in_if
  import pai_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [OpW-1:0]         op;
  logic [PosW-1:0]        position;
  logic signed [ValW-1:0] value;

  modport source (output valid, op, position, value, input ready);
  modport sink   (input valid, op, position, value, output ready);
endinterface

### hw/rtl/pai_out_if.sv
// result channel of the positional array insert/delete unit
interface pai_out_if
  import pai_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [StW-1:0]         status;
  logic [IdxW-1:0]        entry_index;
  logic signed [ValW-1:0] entry_value;
  logic [CountW-1:0]      count_now;
  logic                   last;

  modport source (output valid, status, entry_index, entry_value, count_now, last,
                  input ready);
  modport sink   (input valid, status, entry_index, entry_value, count_now, last,
                  output ready);
endinterface

### hw/rtl/pai_cell.sv
// one storage cell of the shifting entry chain
module pai_cell
  import pai_pkg::*;
(
  input  logic                   clk_i,
  input  sel_e                   sel_i,
  input  logic signed [ValW-1:0] load_i,
  input  logic signed [ValW-1:0] lo_i,
  input  logic signed [ValW-1:0] hi_i,
  input  logic signed [ValW-1:0] head_i,
  output logic signed [ValW-1:0] q_o
);

  logic signed [ValW-1:0] q_q, q_d;

  always_comb begin
    unique case (sel_i)
      SEL_HOLD: q_d = q_q;
      SEL_LOAD: q_d = load_i;
      SEL_LO:   q_d = lo_i;
      SEL_HI:   q_d = hi_i;
      SEL_HEAD: q_d = head_i;
      default:  q_d = q_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
  end

  assign q_o = q_q;

endmodule

### hw/rtl/positional_array_insert_delete_unit.sv
// positional array insert/delete unit: top level
//
// Keeps an ordered list of signed 32-bit words in a chain of DEPTH cells.
// in_i carries one operation word (clear, append, insert at position,
// delete at position, read out); out_o returns result words with status,
// entry index and value, the count after the operation and a last flag.
// Clear, append, insert and delete act at once; insert and delete move the
// cells from the position up. The single result word sits in the output
// register the cycle after the request is taken, so one such request per
// cycle while the receiver takes the words. Read out rotates the occupied
// cells toward cell 0, one step per cycle while its words are taken, and
// gives a word for each of the first 32 steps; requests are refused until
// the rotation has brought the list back. An empty read out gives one word
// with status empty. When the receiver stalls, the output register holds
// its word and the chain stops rotating; a new request is taken while the
// held word leaves. Reset clears the count and the control state; cell
// contents are kept undefined until written.
module positional_array_insert_delete_unit
  import pai_pkg::*;
#(
  parameter int unsigned DEPTH = 32
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  pai_in_if.sink    in_i,
  pai_out_if.source out_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CmpW-1:0] DepthC = CmpW'(DEPTH);
  localparam logic [CmpW-1:0] MaxC   = CmpW'(MaxRead);

  state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] rd_q, rd_d;

  logic                   out_valid_q, out_valid_d;
  logic [StW-1:0]         out_status_q, out_status_d;
  logic [IdxW-1:0]        out_idx_q, out_idx_d;
  logic signed [ValW-1:0] out_val_q, out_val_d;
  logic [CountW-1:0]      out_cnt_q, out_cnt_d;
  logic                   out_last_q, out_last_d;

  logic signed [ValW-1:0] cell_q [DEPTH];
  sel_e                   sel [DEPTH];

  op_e            op;
  logic [CmpW-1:0] cnt7, pos7, rd7, n7;
  logic           slot_free, accept, rd_emit, step, rot, done;
  logic           app_ok, ins_ok, del_ok;
  status_e        status;

  assign op   = op_e'(in_i.op);
  assign cnt7 = CmpW'(count_q);
  assign pos7 = CmpW'(in_i.position);
  assign rd7  = CmpW'(rd_q);
  assign n7   = (cnt7 < MaxC) ? cnt7 : MaxC;
  assign slot_free = !out_valid_q || out_o.ready;
  assign accept    = in_i.valid && in_i.ready;
  assign rd_emit   = rd7 < MaxC;
  assign done      = rd7 == cnt7 - CmpW'(1);

  // request decode
  always_comb begin
    app_ok = 1'b0;
    ins_ok = 1'b0;
    del_ok = 1'b0;
    status = ST_OK;
    unique case (op)
      OP_APPEND: begin
        if (cnt7 >= DepthC) status = ST_FULL;
        else app_ok = 1'b1;
      end
      OP_INSERT: begin
        priority if (cnt7 == '0) status = ST_EMPTY;
        else if (pos7 >= cnt7) status = ST_BAD_POS;
        else if (cnt7 >= DepthC) status = ST_FULL;
        else ins_ok = 1'b1;
      end
      OP_DELETE: begin
        priority if (cnt7 == '0) status = ST_EMPTY;
        else if (pos7 >= cnt7) status = ST_BAD_POS;
        else del_ok = 1'b1;
      end
      OP_READ: begin
        if (cnt7 == '0) status = ST_EMPTY;
      end
      default: status = ST_OK;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept && op == OP_READ && count_q != '0) state_d = S_READ;
      S_READ: if (step && done) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_i.ready   = 1'b0;
    step         = 1'b0;
    rot          = 1'b0;
    count_d      = count_q;
    rd_d         = rd_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_status_d = out_status_q;
    out_idx_d    = out_idx_q;
    out_val_d    = out_val_q;
    out_cnt_d    = out_cnt_q;
    out_last_d   = out_last_q;
    unique case (state_q)
      S_IDLE: begin
        in_i.ready = slot_free;
        if (accept) begin
          unique case (1'b1)
            op == OP_CLEAR: count_d = '0;
            app_ok || ins_ok: count_d = count_q + CW'(1);
            del_ok: count_d = count_q - CW'(1);
            default: count_d = count_q;
          endcase
          rd_d = '0;
          if (!(op == OP_READ && count_q != '0)) begin
            out_valid_d  = 1'b1;
            out_status_d = status;
            out_idx_d    = '0;
            out_val_d    = '0;
            out_cnt_d    = CountW'(count_d);
            out_last_d   = 1'b1;
          end
        end
      end
      S_READ: begin
        step = rd_emit ? slot_free : 1'b1;
        rot  = step;
        if (step) rd_d = rd_q + CW'(1);
        if (rd_emit && slot_free) begin
          out_valid_d  = 1'b1;
          out_status_d = ST_OK;
          out_idx_d    = IdxW'(rd_q);
          out_val_d    = cell_q[0];
          out_cnt_d    = CountW'(count_q);
          out_last_d   = rd7 == n7 - CmpW'(1);
        end
      end
      default: in_i.ready = 1'b0;
    endcase
  end

  // cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [CmpW-1:0] Idx = CmpW'(i);
    logic signed [ValW-1:0] lo, hi;

    if (i > 0) begin : g_lo
      assign lo = cell_q[i-1];
    end else begin : g_lo0
      assign lo = '0;
    end
    if (i < DEPTH - 1) begin : g_hi
      assign hi = cell_q[i+1];
    end else begin : g_hi0
      assign hi = '0;
    end

    always_comb begin
      sel[i] = SEL_HOLD;
      priority if (rot) begin
        if (Idx == cnt7 - CmpW'(1)) sel[i] = SEL_HEAD;
        else if (Idx < cnt7 - CmpW'(1)) sel[i] = SEL_HI;
      end else if (accept && app_ok) begin
        if (Idx == cnt7) sel[i] = SEL_LOAD;
      end else if (accept && ins_ok) begin
        if (Idx == pos7) sel[i] = SEL_LOAD;
        else if (Idx > pos7) sel[i] = SEL_LO;
      end else if (accept && del_ok) begin
        if (Idx >= pos7 && i < DEPTH - 1) sel[i] = SEL_HI;
      end else begin
        sel[i] = SEL_HOLD;
      end
    end

    pai_cell u_cell (
      .clk_i  (clk_i),
      .sel_i  (sel[i]),
      .load_i (in_i.value),
      .lo_i   (lo),
      .hi_i   (hi),
      .head_i (cell_q[0]),
      .q_o    (cell_q[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rd_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_q        <= rd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_idx_q    <= out_idx_d;
    out_val_q    <= out_val_d;
    out_cnt_q    <= out_cnt_d;
    out_last_q   <= out_last_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = out_status_q;
  assign out_o.entry_index = out_idx_q;
  assign out_o.entry_value = out_val_q;
  assign out_o.count_now   = out_cnt_q;
  assign out_o.last        = out_last_q;

endmodule

### hw/rtl/pai_checker.sv
// port checker of the positional array insert/delete unit and its bind
module pai_checker
  import pai_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_ready_i,
  input logic                   out_valid_i,
  input logic                   out_ready_i,
  input logic [StW-1:0]         out_status_i,
  input logic [IdxW-1:0]        out_entry_index_i,
  input logic signed [ValW-1:0] out_entry_value_i,
  input logic [CountW-1:0]      out_count_now_i,
  input logic                   out_last_i
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_entry_value_i)
      && $stable(out_status_i) && $stable(out_last_i))
    else $error("stalled word changed");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_last_i |-> !in_ready_i)
    else $error("request taken during read out");

  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i == ST_EMPTY |-> out_last_i && out_count_now_i == '0)
    else $error("empty status on a non-final word");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i != ST_OK |-> out_entry_value_i == '0
      && out_entry_index_i == '0)
    else $error("refused request carries an entry");

endmodule

bind positional_array_insert_delete_unit pai_checker u_pai_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_ready_i        (in_i.ready),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .out_status_i      (out_o.status),
  .out_entry_index_i (out_o.entry_index),
  .out_entry_value_i (out_o.entry_value),
  .out_count_now_i   (out_o.count_now),
  .out_last_i        (out_o.last)
);
